// ===== design/sap_pkg.sv =====
// ----------------------------------------------------------------------------
// Shelf atlas packer package
// Shared sizes, page record types and result codes of the shelf packer.
// ----------------------------------------------------------------------------
package sap_pkg;

	// Atlas geometry.
	localparam int PAGE_SIZE = 1024;
	localparam int MAX_PAGES = 8;

	// Fixed field widths of the request and result items.
	localparam int COORD_W    = 11;
	localparam int PAD_W      = 4;
	localparam int PAGE_OUT_W = 3;
	localparam int STATUS_W   = 2;

	// Derived internal widths.
	localparam int PIDX_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
	localparam int CNT_W  = $clog2(MAX_PAGES + 1);
	localparam int CUR_W  = $clog2(PAGE_SIZE) + 1;
	localparam int DIM_W  = COORD_W + 1;
	localparam int SUM_W  = ((CUR_W > DIM_W) ? CUR_W : DIM_W) + 2;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_PLACED    = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_TOO_LARGE = 2'd2,
		ST_NO_PAGE   = 2'd3
	} status_t;

	// Packing state of one page.
	typedef struct packed {
		logic [CUR_W-1:0] cx;
		logic [CUR_W-1:0] cy;
		logic [CUR_W-1:0] sh;
	} page_t;

	// Write request into the page store.
	typedef struct packed {
		logic              en;
		logic [PIDX_W-1:0] addr;
		page_t             data;
	} pg_wr_t;

	// Verdict of the fit unit for one page.
	typedef struct packed {
		logic             fit;
		logic [CUR_W-1:0] nx;
		logic [CUR_W-1:0] ny;
		logic [CUR_W-1:0] rh;
	} fit_t;

endpackage

// ===== design/sap_req_if.sv =====
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one rectangle request per item.
// ----------------------------------------------------------------------------
interface sap_req_if;
	logic                        valid;
	logic                        ready;
	logic [sap_pkg::COORD_W-1:0] rect_width;
	logic [sap_pkg::COORD_W-1:0] rect_height;

	modport source (output valid, output rect_width, output rect_height, input ready);
	modport sink (input valid, input rect_width, input rect_height, output ready);
endinterface

// ===== design/sap_res_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one placement result per item.
// ----------------------------------------------------------------------------
interface sap_res_if;
	logic                           valid;
	logic                           ready;
	sap_pkg::status_t               status;
	logic [sap_pkg::PAGE_OUT_W-1:0] atlas_page;
	logic [sap_pkg::COORD_W-1:0]    x_origin;
	logic [sap_pkg::COORD_W-1:0]    y_origin;
	logic [sap_pkg::COORD_W-1:0]    x_end;
	logic [sap_pkg::COORD_W-1:0]    y_end;

	modport source (output valid, output status, output atlas_page, output x_origin,
		output y_origin, output x_end, output y_end, input ready);
	modport sink (input valid, input status, input atlas_page, input x_origin,
		input y_origin, input x_end, input y_end, output ready);
endinterface

// ===== design/sap_fit.sv =====
// ----------------------------------------------------------------------------
// Shelf fit unit
// Tests one page against a padded request: shelf wrap and height check.
// ----------------------------------------------------------------------------
module sap_fit (
	input  sap_pkg::page_t                 page,
	input  logic [sap_pkg::DIM_W-1:0]      pw,
	input  logic [sap_pkg::DIM_W-1:0]      ph,
	input  logic [sap_pkg::PAD_W-1:0]      pad,
	output sap_pkg::fit_t                  verdict
);
	logic [sap_pkg::SUM_W-1:0] x_sum;
	logic [sap_pkg::SUM_W-1:0] y_base;
	logic [sap_pkg::SUM_W-1:0] y_sum;
	logic                      wrap;

	// The shelf wraps when the request runs past the right edge.
	assign x_sum = sap_pkg::SUM_W'(page.cx) + sap_pkg::SUM_W'(pw);
	assign wrap  = x_sum > sap_pkg::SUM_W'(sap_pkg::PAGE_SIZE);

	// A wrapped request starts below the current shelf.
	assign y_base = wrap ? (sap_pkg::SUM_W'(page.cy) + sap_pkg::SUM_W'(page.sh))
		: sap_pkg::SUM_W'(page.cy);
	assign y_sum  = y_base + sap_pkg::SUM_W'(ph);

	// Verdict and the cursor the placement would start from.
	always_comb begin
		verdict.fit = y_sum <= sap_pkg::SUM_W'(sap_pkg::PAGE_SIZE);
		verdict.nx  = wrap ? sap_pkg::CUR_W'(pad) : page.cx;
		verdict.ny  = y_base[sap_pkg::CUR_W-1:0];
		verdict.rh  = wrap ? '0 : page.sh;
	end
endmodule

// ===== design/sap_pages.sv =====
// ----------------------------------------------------------------------------
// Page store
// Cursor and shelf height of every atlas page, one write and one read port.
// ----------------------------------------------------------------------------
module sap_pages (
	input  logic                        clk,
	input  sap_pkg::pg_wr_t             wr,
	input  logic [sap_pkg::PIDX_W-1:0]  rd_addr,
	output sap_pkg::page_t              rd_data
);
	sap_pkg::page_t pages_q [sap_pkg::MAX_PAGES];
	sap_pkg::page_t rd_q;

	// Entries are written when a page opens or takes a rectangle.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			pages_q[wr.addr] <= wr.data;
		end
	end

	// Registered read; the address is driven ahead of the scan to cover the read register.
	always_ff @(posedge clk) begin
		rd_q <= pages_q[rd_addr];
	end

	assign rd_data = rd_q;
endmodule

// ===== design/shelf_atlas_packer.sv =====
// ----------------------------------------------------------------------------
// Shelf atlas packer
// Places rectangle requests on square atlas pages by first-fit shelf packing.
// ----------------------------------------------------------------------------
// Usage: a request item (rect_width, rect_height) enters on req; one result
// item (status, atlas_page, origin and end coordinates) leaves on res for
// every request. cfg_we with cfg_wdata sets the padding kept around each
// rectangle; write it only while no request is in flight.
// Timing: a request passes the setup state, one scan state per page examined
// (plus one more when no open page fits), the placement state when a page
// takes it and the emit state that loads the result register; empty or
// oversize requests go from setup straight to emit. The scan through the page
// store, one page per cycle through the shared fit unit, is the part that
// grows with the pages open. req.ready is high only between requests, in the
// idle state entered once the result has loaded.
// Reset: all pages close, padding returns to 1 and no result is pending.
// Stall: a result waits in the output register while res.ready is low; the
// next request is accepted meanwhile and its result waits until the register
// frees.
// ----------------------------------------------------------------------------
module shelf_atlas_packer (
	input  logic                       clk,
	input  logic                       arst_n,
	sap_req_if.sink                    req,
	sap_res_if.source                  res,
	input  logic                       cfg_we,
	input  logic [sap_pkg::PAD_W-1:0]  cfg_wdata
);
	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SETUP = 5'b00010,
		S_SCAN  = 5'b00100,
		S_PLACE = 5'b01000,
		S_EMIT  = 5'b10000
	} state_t;

	localparam int SUM_W = sap_pkg::SUM_W;
	localparam int CUR_W = sap_pkg::CUR_W;
	localparam int CW    = sap_pkg::COORD_W;

	state_t                        state_q;
	logic [sap_pkg::PAD_W-1:0]     pad_q;
	logic [sap_pkg::CNT_W-1:0]     pages_open_q;
	logic [sap_pkg::CNT_W-1:0]     scan_q;
	logic [sap_pkg::CNT_W-1:0]     scan_nxt;
	logic [CW-1:0]                 w_q;
	logic [CW-1:0]                 h_q;
	logic [sap_pkg::DIM_W-1:0]     pw_q;
	logic [sap_pkg::DIM_W-1:0]     ph_q;
	logic [sap_pkg::PIDX_W-1:0]    sel_q;
	logic [CUR_W-1:0]              nx_q;
	logic [CUR_W-1:0]              ny_q;
	logic [CUR_W-1:0]              rh_q;

	// Pending result, copied to the output register once it is free.
	sap_pkg::status_t              rs_status_q;
	logic [sap_pkg::PAGE_OUT_W-1:0] rs_page_q;
	logic [CW-1:0]                 rs_x0_q;
	logic [CW-1:0]                 rs_y0_q;
	logic [CW-1:0]                 rs_x1_q;
	logic [CW-1:0]                 rs_y1_q;

	logic                          res_valid_q;
	sap_pkg::status_t              res_status_q;
	logic [sap_pkg::PAGE_OUT_W-1:0] res_page_q;
	logic [CW-1:0]                 res_x0_q;
	logic [CW-1:0]                 res_y0_q;
	logic [CW-1:0]                 res_x1_q;
	logic [CW-1:0]                 res_y1_q;

	sap_pkg::pg_wr_t               pg_wr;
	sap_pkg::page_t                pg_rd;
	sap_pkg::fit_t                 verdict;

	logic [sap_pkg::DIM_W-1:0]     pw_new;
	logic [sap_pkg::DIM_W-1:0]     ph_new;
	logic [SUM_W-1:0]              x0_sum;
	logic [SUM_W-1:0]              y0_sum;
	logic [SUM_W-1:0]              x1_sum;
	logic [SUM_W-1:0]              y1_sum;
	logic [SUM_W-1:0]              cx_next;
	logic [sap_pkg::PIDX_W+sap_pkg::PAGE_OUT_W-1:0] sel_ext;
	logic                          out_free;
	logic                          scan_end;
	logic                          oversize;

	// Page store and the shared fit unit.
	sap_pages u_pages (
		.clk     (clk),
		.wr      (pg_wr),
		.rd_addr (scan_nxt[sap_pkg::PIDX_W-1:0]),
		.rd_data (pg_rd)
	);

	sap_fit u_fit (
		.page    (pg_rd),
		.pw      (pw_q),
		.ph      (ph_q),
		.pad     (pad_q),
		.verdict (verdict)
	);

	// Page to be examined in the next cycle, so the store read is ready in time.
	always_comb begin
		scan_nxt = scan_q;
		if (state_q == S_SETUP) begin
			scan_nxt = '0;
		end else if (state_q == S_SCAN && !scan_end && !verdict.fit) begin
			scan_nxt = scan_q + 1'b1;
		end
	end

	// Padded size and the oversize check.
	assign pw_new   = sap_pkg::DIM_W'(w_q) + sap_pkg::DIM_W'({pad_q, 1'b0});
	assign ph_new   = sap_pkg::DIM_W'(h_q) + sap_pkg::DIM_W'({pad_q, 1'b0});
	assign oversize = (SUM_W'(pw_new) > SUM_W'(sap_pkg::PAGE_SIZE))
		|| (SUM_W'(ph_new) > SUM_W'(sap_pkg::PAGE_SIZE));

	// Placement arithmetic from the chosen cursor.
	assign x0_sum  = SUM_W'(nx_q) + SUM_W'(pad_q);
	assign y0_sum  = SUM_W'(ny_q) + SUM_W'(pad_q);
	assign x1_sum  = x0_sum + SUM_W'(w_q);
	assign y1_sum  = y0_sum + SUM_W'(h_q);
	assign cx_next = SUM_W'(nx_q) + SUM_W'(pw_q);
	assign sel_ext = {{sap_pkg::PAGE_OUT_W{1'b0}}, sel_q};

	// Page update happens in the placement cycle.
	always_comb begin
		pg_wr.en      = state_q == S_PLACE;
		pg_wr.addr    = sel_q;
		pg_wr.data.cx = cx_next[CUR_W-1:0];
		pg_wr.data.cy = ny_q;
		pg_wr.data.sh = (SUM_W'(ph_q) > SUM_W'(rh_q)) ? CUR_W'(ph_q) : rh_q;
	end

	assign scan_end = scan_q == pages_open_q;
	assign out_free = !res_valid_q || res.ready;
	assign req.ready = state_q == S_IDLE;

	// Padding register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_q <= sap_pkg::PAD_W'(1);
		end else if (cfg_we) begin
			pad_q <= cfg_wdata;
		end
	end

	// Sequencer: setup, page scan, placement, result hand-off.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			pages_open_q <= '0;
			scan_q       <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						state_q <= S_SETUP;
					end
				end
				S_SETUP: begin
					scan_q <= '0;
					if (w_q == '0 || h_q == '0 || oversize) begin
						state_q <= S_EMIT;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (scan_end) begin
						if (pages_open_q == sap_pkg::CNT_W'(sap_pkg::MAX_PAGES)) begin
							state_q <= S_EMIT;
						end else begin
							pages_open_q <= pages_open_q + 1'b1;
							state_q      <= S_PLACE;
						end
					end else if (verdict.fit) begin
						state_q <= S_PLACE;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				S_PLACE: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Working registers of the request under way.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				w_q <= req.rect_width;
				h_q <= req.rect_height;
			end
			S_SETUP: begin
				pw_q        <= pw_new;
				ph_q        <= ph_new;
				rs_page_q   <= '0;
				rs_x0_q     <= '0;
				rs_y0_q     <= '0;
				rs_x1_q     <= '0;
				rs_y1_q     <= '0;
				if (w_q == '0 || h_q == '0) begin
					rs_status_q <= sap_pkg::ST_EMPTY;
				end else begin
					rs_status_q <= sap_pkg::ST_TOO_LARGE;
				end
			end
			S_SCAN: begin
				if (scan_end) begin
					rs_status_q <= sap_pkg::ST_NO_PAGE;
					sel_q       <= pages_open_q[sap_pkg::PIDX_W-1:0];
					nx_q        <= CUR_W'(pad_q);
					ny_q        <= CUR_W'(pad_q);
					rh_q        <= '0;
				end else begin
					sel_q <= scan_q[sap_pkg::PIDX_W-1:0];
					nx_q  <= verdict.nx;
					ny_q  <= verdict.ny;
					rh_q  <= verdict.rh;
				end
			end
			S_PLACE: begin
				rs_status_q <= sap_pkg::ST_PLACED;
				rs_page_q   <= sel_ext[sap_pkg::PAGE_OUT_W-1:0];
				rs_x0_q     <= x0_sum[CW-1:0];
				rs_y0_q     <= y0_sum[CW-1:0];
				rs_x1_q     <= x1_sum[CW-1:0];
				rs_y1_q     <= y1_sum[CW-1:0];
			end
			S_EMIT: begin
			end
			default: begin
			end
		endcase
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == S_EMIT && out_free) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && out_free) begin
			res_status_q <= rs_status_q;
			res_page_q   <= rs_page_q;
			res_x0_q     <= rs_x0_q;
			res_y0_q     <= rs_y0_q;
			res_x1_q     <= rs_x1_q;
			res_y1_q     <= rs_y1_q;
		end
	end

	assign res.valid      = res_valid_q;
	assign res.status     = res_status_q;
	assign res.atlas_page = res_page_q;
	assign res.x_origin   = res_x0_q;
	assign res.y_origin   = res_y0_q;
	assign res.x_end      = res_x1_q;
	assign res.y_end      = res_y1_q;

	// The open page count never passes the number of pages.
	a_pages_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pages_open_q <= sap_pkg::CNT_W'(sap_pkg::MAX_PAGES))
		else $error("open page count exceeds the page total");

	// Pages open one at a time and never close outside reset.
	a_pages_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (pages_open_q == $past(pages_open_q))
		|| (pages_open_q == $past(pages_open_q) + 1'b1))
		else $error("open page count moved by more than one");

	// A page is written only once it is open.
	a_write_open: assert property (@(posedge clk) disable iff (!arst_n)
		pg_wr.en |-> (sap_pkg::CNT_W'(sel_q) < pages_open_q))
		else $error("page store written beyond the open pages");

	// A result that is not a placement carries zero coordinates.
	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.status != sap_pkg::ST_PLACED) |->
		(res.atlas_page == '0 && res.x_origin == '0 && res.y_origin == '0
		&& res.x_end == '0 && res.y_end == '0))
		else $error("fault result carries a placement");
endmodule
